### rtl/priority_based_task_picker_macros.svh
// ----------------------------------------------------------------------------
// priority based task picker assertion macros
// shared assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BASED_TASK_PICKER_MACROS_SVH
`define PRIORITY_BASED_TASK_PICKER_MACROS_SVH

// clocked assertion with reset disable
`define PBTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion checked during reset as well
`define PBTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/pbtp_pkg.sv
// ----------------------------------------------------------------------------
// pbtp package
// shared types and constants of the priority based task picker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbtp_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int PRIO_W   = 7;
  localparam int PRIO_MAX = 100;
  localparam int NICE_W   = 4;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_CREATE  = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_BLOCK   = 3'd3,
    MODE_FREE    = 3'd4,
    MODE_SETPRIO = 3'd5,
    MODE_PICK    = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [PRIO_W-1:0] static_prio;
    logic              fresh;
    logic [31:0]       run_count;
    logic [31:0]       creation;
    logic [31:0]       recent;
    logic [31:0]       dispatch;
    logic [31:0]       release_t;
  } rec_t;

  typedef struct packed {
    logic        fresh;
    logic [31:0] release_t;
    logic [31:0] dispatch;
    logic [31:0] recent;
  } nice_req_t;

  function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] v);
    logic [PRIO_W-1:0] r;
    r = (v > PRIO_W'(PRIO_MAX)) ? PRIO_W'(PRIO_MAX) : v;
    return r;
  endfunction

endpackage

### rtl/pbtp_nice.sv
// ----------------------------------------------------------------------------
// pbtp niceness unit
// iterative 10*sleep/(sleep+run) with a four step restoring divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbtp_nice import pbtp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  nice_req_t         req_i,
  output logic              done_o,
  output logic [NICE_W-1:0] nice_o
);

  typedef enum logic [4:0] {
    N_IDLE  = 5'b00001,
    N_PREP  = 5'b00010,
    N_SCALE = 5'b00100,
    N_DIV   = 5'b01000,
    N_DONE  = 5'b10000
  } nstate_e;

  nstate_e           state_q, state_d;
  nice_req_t         req_q;
  logic [32:0]       slp_q, slp_d;
  logic [33:0]       den_q, den_d;
  logic [36:0]       rem_q, rem_d;
  logic [NICE_W-1:0] q_q, q_d;
  logic [1:0]        step_q, step_d;
  logic [33:0]       sl;
  logic [37:0]       trial;

  assign sl     = {2'b0, req_q.release_t} - {2'b0, req_q.dispatch} + {2'b0, req_q.recent};
  assign trial  = {4'b0, den_q} << step_q;
  assign done_o = (state_q == N_DONE);
  assign nice_o = q_q;

  always_comb begin
    state_d = state_q;
    slp_d   = slp_q;
    den_d   = den_q;
    rem_d   = rem_q;
    q_d     = q_q;
    step_d  = step_q;
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          state_d = N_PREP;
        end
      end
      N_PREP: begin
        slp_d   = sl[33] ? 33'd0 : sl[32:0];
        state_d = N_SCALE;
      end
      N_SCALE: begin
        den_d  = {1'b0, slp_q} + {2'b0, req_q.recent};
        rem_d  = {1'b0, slp_q, 3'b0} + {3'b0, slp_q, 1'b0};
        q_d    = '0;
        step_d = 2'd3;
        if (req_q.fresh || (den_d == '0)) begin
          q_d     = NICE_W'(5);
          state_d = N_DONE;
        end else begin
          state_d = N_DIV;
        end
      end
      N_DIV: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_d = rem_q - trial[36:0];
          q_d   = q_q | (NICE_W'(1) << step_q);
        end
        step_d = step_q - 2'd1;
        if (step_q == 2'd0) begin
          state_d = N_DONE;
        end
      end
      N_DONE: begin
        state_d = N_IDLE;
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == N_IDLE)) begin
      req_q <= req_i;
    end
    slp_q  <= slp_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    q_q    <= q_d;
    step_q <= step_d;
  end

endmodule

### rtl/priority_based_task_picker.sv
// tick sweeps all 64 slots, one a cycle, but each running slot adds a read and a write
// pick sweeps all slots; each runnable slot waits on the niceness divider
// others end at decode or a read and write; one item at a time, next accepted once idle
// rst_ni clears time, slot status, default priority and control; no clearing pass
`timescale 1ns / 1ps

module priority_based_task_picker import pbtp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PRIO_W-1:0] cfg_wdata_i,   // default_priority
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // mode[2:0] slot[8:3] priority_req[15:9]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata   // found[0] chosen_slot[6:1]
                                           // chosen_priority[13:7] previous_priority[20:14]
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'h0001,
    S_DECODE    = 15'h0002,
    S_RMW_RD    = 15'h0004,
    S_RMW_WR    = 15'h0008,
    S_TICK_CHK  = 15'h0010,
    S_TICK_RD   = 15'h0020,
    S_TICK_WR   = 15'h0040,
    S_SCAN_CHK  = 15'h0080,
    S_SCAN_RD   = 15'h0100,
    S_SCAN_WAIT = 15'h0200,
    S_SCAN_NICE = 15'h0400,
    S_SCAN_UPD  = 15'h0800,
    S_WIN_RD    = 15'h1000,
    S_WIN_WR    = 15'h2000,
    S_DONE      = 15'h4000
  } state_e;

  state_e            state_q, state_d;
  logic [PRIO_W-1:0] dflt_q;
  logic [31:0]       time_q, time_d;
  status_e           status_q [SLOTS];
  rec_t              mem [SLOTS];
  rec_t              rdata_q;

  logic [2:0]        mode_q;
  logic [5:0]        slot_q;
  logic [PRIO_W-1:0] req_q;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] best_q, best_d;
  logic [PRIO_W-1:0] bestp_q, bestp_d;
  logic [31:0]       best_run_q, best_run_d;
  logic [31:0]       best_cre_q, best_cre_d;
  logic              have_q, have_d;
  logic              found_q, found_d;
  logic [PRIO_W-1:0] cprio_q, cprio_d;
  logic [PRIO_W-1:0] prev_q, prev_d;
  logic              m_valid_q;
  logic [23:0]       m_data_q;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  rec_t              mem_wd;
  logic [SLOT_W-1:0] rd_addr;
  logic              st_we;
  logic [SLOT_W-1:0] st_wa;
  status_e           st_wd;

  logic              ok;
  logic [SLOT_W-1:0] slot_idx;
  status_e           slot_st;
  logic              last;
  logic              nice_start;
  logic              nice_done;
  logic [NICE_W-1:0] nice;
  nice_req_t         nice_req;
  logic [8:0]        dtmp;
  logic [PRIO_W-1:0] dprio;
  logic              better;
  logic              accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign ok       = (32'(slot_q) < SLOTS);
  assign slot_idx = SLOT_W'(slot_q);
  assign slot_st  = status_q[slot_idx];
  assign last     = (idx_q == SLOT_W'(SLOTS - 1));

  assign nice_start         = (state_q == S_SCAN_WAIT);
  assign nice_req.fresh     = rdata_q.fresh;
  assign nice_req.release_t = rdata_q.release_t;
  assign nice_req.dispatch  = rdata_q.dispatch;
  assign nice_req.recent    = rdata_q.recent;

  pbtp_nice u_nice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nice_start),
    .req_i   (nice_req),
    .done_o  (nice_done),
    .nice_o  (nice)
  );

  assign dtmp  = {2'b0, rdata_q.static_prio} + 9'd5 - {5'b0, nice};
  assign dprio = dtmp[8] ? '0 :
                 (dtmp > 9'(PRIO_MAX)) ? PRIO_W'(PRIO_MAX) : dtmp[PRIO_W-1:0];
  assign better = !have_q || (dprio < bestp_q)
                  || ((dprio == bestp_q) && (rdata_q.run_count < best_run_q))
                  || ((dprio == bestp_q) && (rdata_q.run_count == best_run_q)
                      && (rdata_q.creation < best_cre_q));

  always_comb begin
    case (state_q)
      S_WIN_RD, S_WIN_WR: rd_addr = best_q;
      S_TICK_CHK, S_TICK_RD, S_TICK_WR, S_SCAN_CHK, S_SCAN_RD, S_SCAN_WAIT,
      S_SCAN_NICE, S_SCAN_UPD: rd_addr = idx_q;
      default: rd_addr = slot_idx;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    time_d     = time_q;
    idx_d      = idx_q;
    best_d     = best_q;
    bestp_d    = bestp_q;
    best_run_d = best_run_q;
    best_cre_d = best_cre_q;
    have_d     = have_q;
    found_d    = found_q;
    cprio_d    = cprio_q;
    prev_d     = prev_q;
    mem_we     = 1'b0;
    mem_wa     = slot_idx;
    mem_wd     = rdata_q;
    st_we      = 1'b0;
    st_wa      = slot_idx;
    st_wd      = ST_UNUSED;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          found_d = 1'b0;
          cprio_d = '0;
          prev_d  = '0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (mode_q)
          MODE_TICK: begin
            time_d  = time_q + 32'd1;
            idx_d   = '0;
            state_d = S_TICK_CHK;
          end
          MODE_CREATE: begin
            if (ok && (slot_st == ST_UNUSED)) begin
              mem_we             = 1'b1;
              mem_wd.static_prio = sat_prio(dflt_q);
              mem_wd.fresh       = 1'b1;
              mem_wd.run_count   = '0;
              mem_wd.recent      = '0;
              mem_wd.creation    = time_q;
              mem_wd.dispatch    = time_q;
              mem_wd.release_t   = time_q;
              st_we              = 1'b1;
              st_wd              = ST_RUNNABLE;
            end
          end
          MODE_RELEASE: begin
            if (ok && ((slot_st == ST_RUNNING) || (slot_st == ST_BLOCKED))) begin
              st_we   = 1'b1;
              st_wd   = ST_RUNNABLE;
              state_d = S_RMW_RD;
            end
          end
          MODE_BLOCK: begin
            if (ok && (slot_st != ST_UNUSED)) begin
              st_we = 1'b1;
              st_wd = ST_BLOCKED;
            end
          end
          MODE_FREE: begin
            if (ok) begin
              st_we = 1'b1;
              st_wd = ST_UNUSED;
            end
          end
          MODE_SETPRIO: begin
            if (ok && (slot_st != ST_UNUSED)) begin
              state_d = S_RMW_RD;
            end
          end
          MODE_PICK: begin
            idx_d   = '0;
            have_d  = 1'b0;
            state_d = S_SCAN_CHK;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RMW_RD: begin
        state_d = S_RMW_WR;
      end
      S_RMW_WR: begin
        mem_we = 1'b1;
        if (mode_q == MODE_RELEASE) begin
          mem_wd.release_t = time_q;
        end else begin
          prev_d             = rdata_q.static_prio;
          mem_wd.static_prio = sat_prio(req_q);
          mem_wd.fresh       = 1'b1;
        end
        state_d = S_DONE;
      end
      S_TICK_CHK: begin
        if (status_q[idx_q] == ST_RUNNING) begin
          state_d = S_TICK_RD;
        end else if (last) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TICK_RD: begin
        state_d = S_TICK_WR;
      end
      S_TICK_WR: begin
        mem_we        = 1'b1;
        mem_wa        = idx_q;
        mem_wd.recent = rdata_q.recent + 32'd1;
        if (last) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_TICK_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (status_q[idx_q] == ST_RUNNABLE) begin
          state_d = S_SCAN_RD;
        end else if (last) begin
          state_d = have_q ? S_WIN_RD : S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        state_d = S_SCAN_NICE;
      end
      S_SCAN_NICE: begin
        if (nice_done) begin
          state_d = S_SCAN_UPD;
        end
      end
      S_SCAN_UPD: begin
        mem_we       = 1'b1;
        mem_wa       = idx_q;
        mem_wd.fresh = 1'b0;
        if (better) begin
          have_d     = 1'b1;
          best_d     = idx_q;
          bestp_d    = dprio;
          best_run_d = rdata_q.run_count;
          best_cre_d = rdata_q.creation;
        end
        if (last) begin
          state_d = have_d ? S_WIN_RD : S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN_CHK;
        end
      end
      S_WIN_RD: begin
        state_d = S_WIN_WR;
      end
      S_WIN_WR: begin
        mem_we           = 1'b1;
        mem_wa           = best_q;
        mem_wd.dispatch  = time_q;
        mem_wd.run_count = rdata_q.run_count + 32'd1;
        mem_wd.recent    = '0;
        st_we            = 1'b1;
        st_wa            = best_q;
        st_wd            = ST_RUNNING;
        found_d          = 1'b1;
        cprio_d          = bestp_q;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dflt_q    <= PRIO_W'(60);
      time_q    <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        status_q[i] <= ST_UNUSED;
      end
    end else begin
      state_q <= state_d;
      time_q  <= time_d;
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
      if (st_we) begin
        status_q[st_wa] <= st_wd;
      end
      if ((state_q == S_DONE) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_axis_tdata[2:0];
      slot_q <= s_axis_tdata[8:3];
      req_q  <= s_axis_tdata[15:9];
    end
    idx_q      <= idx_d;
    best_q     <= best_d;
    bestp_q    <= bestp_d;
    best_run_q <= best_run_d;
    best_cre_q <= best_cre_d;
    have_q     <= have_d;
    found_q    <= found_d;
    cprio_q    <= cprio_d;
    prev_q     <= prev_d;
    if ((state_q == S_DONE) && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {3'b0, prev_q, cprio_q, (found_q ? 6'(best_q) : 6'd0), found_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[rd_addr];
  end

endmodule

### rtl/pbtp_checker.sv
// ----------------------------------------------------------------------------
// pbtp checker
// port level checks on the task picker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "priority_based_task_picker_macros.svh"

module pbtp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `PBTP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result item dropped")
  `PBTP_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result item changed while stalled")
  `PBTP_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "item accepted while busy")
  `PBTP_ASSERT(a_no_find_zero, m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[13:1] == 13'd0), "empty pick carries a slot or priority")
  `PBTP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "result item during reset")

endmodule

bind priority_based_task_picker pbtp_checker u_pbtp_checker (.*);
